// ===== rtl/dsis_pkg.sv =====
// Shared types and constants for the depth-image stereo shift core.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dsis_pkg;

   localparam int MAX_SHIFT_DEFAULT = 7;

   localparam int COLOR_W  = 8;
   localparam int DEPTH_W  = 8;
   localparam int GAIN_W   = 8;
   localparam int OFFSET_W = 10;

   // Product of gain and depth, and the divisor offset plus depth.
   localparam int PROD_W = GAIN_W + DEPTH_W;
   localparam int DEN_W  = OFFSET_W + 1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = OFFSET_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET = 1'b1;

   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 8'd10;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd85;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red_in;
      logic [COLOR_W-1:0] green_in;
      logic [COLOR_W-1:0] blue_in;
      logic [DEPTH_W-1:0] depth;
      logic               row_end;
   } req_word_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red_out;
      logic [COLOR_W-1:0] green_out;
      logic [COLOR_W-1:0] blue_out;
      logic               row_done;
   } rsp_word_type;

   typedef struct packed {
      logic shift;
      logic load_pix;
      logic load_red;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/dsis_req_if.sv =====
// Input channel of the stereo shift core: valid/ready plus one source pixel word.
// Depends on dsis_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dsis_req_if;
   import dsis_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dsis_rsp_if.sv =====
// Result channel of the stereo shift core: valid/ready plus one output pixel word.
// Depends on dsis_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dsis_rsp_if;
   import dsis_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dsis_div.sv =====
// Iterative disparity unit: gain*depth / (offset+depth), saturated to MAX_SHIFT.
// A multiply on start, one range check, then one quotient bit per cycle. Uses dsis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsis_div #(
   parameter int MAX_SHIFT = dsis_pkg::MAX_SHIFT_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [dsis_pkg::GAIN_W-1:0]   gain,
   input  wire logic [dsis_pkg::OFFSET_W-1:0] offset,
   input  wire logic [dsis_pkg::DEPTH_W-1:0]  depth,
   output logic                               done,
   output logic [$clog2(MAX_SHIFT+1)-1:0]     quot
);
   import dsis_pkg::*;

   localparam int QW    = $clog2(MAX_SHIFT + 1);
   localparam int KW    = $clog2(QW + 1);
   localparam int CMP_W = PROD_W + QW;
   localparam logic [QW-1:0] QMAX = QW'(MAX_SHIFT);

   logic              busy_ff, busy_in;
   logic              chk_ff, chk_in;
   logic              done_ff, done_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [QW-1:0]     q_ff, q_in;

   logic [CMP_W-1:0]  rem_ext;
   logic [CMP_W-1:0]  den_top;
   logic [CMP_W-1:0]  den_k;

   always_comb begin
      rem_ext = CMP_W'(rem_ff);
      den_top = CMP_W'(den_ff) << QW;
      den_k   = CMP_W'(den_ff) << k_ff;

      busy_in = busy_ff;
      chk_in  = chk_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;

      if (start) begin
         rem_in  = PROD_W'(gain) * PROD_W'(depth);
         den_in  = DEN_W'(offset) + DEN_W'(depth);
         q_in    = '0;
         busy_in = 1'b1;
         chk_in  = 1'b1;
      end else if (busy_ff && chk_ff) begin
         // A zero divisor only happens with a zero product; the result is zero.
         if (den_ff == '0) begin
            q_in    = '0;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (rem_ext >= den_top) begin
            q_in    = QMAX;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            chk_in = 1'b0;
            k_in   = KW'(QW - 1);
         end
      end else if (busy_ff) begin
         if (rem_ext >= den_k) begin
            rem_in = rem_ff - den_k[PROD_W-1:0];
            q_in   = q_ff | (QW'(1) << k_ff);
         end
         if (k_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff - KW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         chk_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         chk_ff  <= chk_in;
         done_ff <= done_in;
      end
      k_ff   <= k_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = (q_ff > QMAX) ? QMAX : q_ff;

endmodule

`default_nettype wire

// ===== rtl/dsis_cell.sv =====
// One column of the pixel window: holds a pixel, loads a new pixel or a
// shifted red, or takes its right neighbor's pixel. Uses dsis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsis_cell (
   input  wire logic                    clock,
   input  wire dsis_pkg::cell_ctrl_type ctrl,
   input  wire dsis_pkg::pixel_type     pix_in,
   input  wire dsis_pkg::pixel_type     neighbor,
   output dsis_pkg::pixel_type          pix_out
);
   import dsis_pkg::*;

   pixel_type pix_ff, pix_next_in;

   always_comb begin
      pix_next_in = pix_ff;
      if (ctrl.shift) begin
         pix_next_in = neighbor;
      end else begin
         if (ctrl.load_pix) begin
            pix_next_in = pix_in;
         end
         // A red copy aimed at this column wins over the column's own red.
         if (ctrl.load_red) begin
            pix_next_in.red = pix_in.red;
         end
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_next_in;
   end

   assign pix_out = pix_ff;

endmodule

`default_nettype wire

// ===== rtl/depth_image_stereo_shift_core.sv =====
// Depth-image stereo shift core. Each input word is one RGB pixel with its depth;
// its red is copied leftward by a disparity of gain*depth/(offset+depth), capped at
// MAX_SHIFT, into a row of MAX_SHIFT+1 window cells. One word is processed at a
// time: the next word is taken only after the iterative divider, which yields one
// quotient bit per cycle, is done with it and any emission it causes is made; when
// the quotient saturates or the divisor is zero the divider stops after its range
// check. A word that completes a column emits that column, and a row-end word emits
// each pixel still in the window; each emission waits while the previous result is
// still held and not taken.
// Results trail the input by MAX_SHIFT pixels and the last result of a row carries
// row_done. Results wait in an output register, so a new word can be taken while
// the previous result is still unclaimed. Configuration writes are for the user
// to make only while idle; the block itself does not enforce this.
// Depends on dsis_pkg, dsis_req_if, dsis_rsp_if, dsis_div and dsis_cell.
`timescale 1ns / 1ps
`default_nettype none

module depth_image_stereo_shift_core #(
   parameter int MAX_SHIFT = dsis_pkg::MAX_SHIFT_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   dsis_req_if.sink                              req_chan,
   dsis_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [dsis_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [dsis_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dsis_pkg::*;

   localparam int WIN = MAX_SHIFT + 1;
   localparam int PW  = $clog2(WIN);
   localparam int FW  = $clog2(WIN + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic                at_start_ff, at_start_in;
   logic                flush_ff, flush_in;
   logic                out_valid_ff, out_valid_in;
   rsp_word_type        out_ff, out_in;
   pixel_type           pix_ff, pix_in;
   logic                row_end_ff, row_end_in;
   logic [GAIN_W-1:0]   gain_ff;
   logic [OFFSET_W-1:0] offset_ff;

   logic                accept;
   logic                div_done;
   logic [PW-1:0]       disp;
   logic [PW-1:0]       pos;
   logic [PW-1:0]       tgt;
   logic                red_ok;
   logic                write_en;
   logic                emit_go;

   pixel_type           cell_q [WIN];
   cell_ctrl_type       cell_ctrl [WIN];

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   dsis_div #(
      .MAX_SHIFT(MAX_SHIFT)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .gain   (gain_ff),
      .offset (offset_ff),
      .depth  (req_chan.data.depth),
      .done   (div_done),
      .quot   (disp)
   );

   // Fill never exceeds MAX_SHIFT outside of emission, so it fits a cell index.
   assign pos      = fill_ff[PW-1:0];
   assign tgt      = pos - disp;
   assign red_ok   = (disp <= pos) && !(at_start_ff && (tgt == '0));
   assign write_en = (state_ff == ST_DIV) && div_done;
   assign emit_go  = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_chan.ready);

   for (genvar i = 0; i < WIN; i++) begin : g_cell
      assign cell_ctrl[i].shift    = emit_go;
      assign cell_ctrl[i].load_pix = write_en && (pos == PW'(i));
      assign cell_ctrl[i].load_red = write_en && red_ok && (tgt == PW'(i));

      dsis_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl[i]),
         .pix_in   (pix_ff),
         .neighbor (cell_q[(i + 1 < WIN) ? i + 1 : i]),
         .pix_out  (cell_q[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      at_start_in  = at_start_ff;
      flush_in     = flush_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      pix_in       = pix_ff;
      row_end_in   = row_end_ff;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pix_in.red   = req_chan.data.red_in;
               pix_in.green = req_chan.data.green_in;
               pix_in.blue  = req_chan.data.blue_in;
               row_end_in   = req_chan.data.row_end;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               fill_in = fill_ff + FW'(1);
               if (row_end_ff) begin
                  flush_in = 1'b1;
                  state_in = ST_EMIT;
               end else if (fill_ff + FW'(1) == FW'(WIN)) begin
                  flush_in = 1'b0;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               out_in.red_out   = cell_q[0].red;
               out_in.green_out = cell_q[0].green;
               out_in.blue_out  = cell_q[0].blue;
               out_in.row_done  = flush_ff && (fill_ff == FW'(1));
               out_valid_in     = 1'b1;
               fill_in          = fill_ff - FW'(1);
               if (!flush_ff) begin
                  at_start_in = 1'b0;
                  state_in    = ST_IDLE;
               end else if (fill_ff == FW'(1)) begin
                  at_start_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         at_start_ff  <= 1'b1;
         flush_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         gain_ff      <= GAIN_RESET;
         offset_ff    <= OFFSET_RESET;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         at_start_ff  <= at_start_in;
         flush_ff     <= flush_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_GAIN:   gain_ff   <= csr_wdata[GAIN_W-1:0];
               CSR_OFFSET: offset_ff <= csr_wdata[OFFSET_W-1:0];
               default:    gain_ff   <= gain_ff;
            endcase
         end
      end
      out_ff     <= out_in;
      pix_ff     <= pix_in;
      row_end_ff <= row_end_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

endmodule

`default_nettype wire

// ===== dv/tb_depth_image_stereo_shift_core.sv =====
// Testbench for depth_image_stereo_shift_core: random and directed pixel rows, random
// handshake idling, and a scoreboard fed by a cycle-free model of the red shift window.
// Depends on dsis_pkg, dsis_req_if, dsis_rsp_if and the core itself.
`timescale 1ns / 1ps

module tb_depth_image_stereo_shift_core;
   import dsis_pkg::*;

   localparam int MAX_SHIFT    = MAX_SHIFT_DEFAULT;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   dsis_req_if req_chan ();
   dsis_rsp_if rsp_chan ();

   depth_image_stereo_shift_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Model state: the window of held pixels of the current row and the settings.
   pixel_type         window_px [0:MAX_SHIFT];
   int unsigned       held_pixels    = 0;
   bit                first_col_held = 1'b1;
   logic [GAIN_W-1:0]   gain_setting   = GAIN_RESET;
   logic [OFFSET_W-1:0] offset_setting = OFFSET_RESET;

   req_word_type pixel_queue [$];
   rsp_word_type shifted_expected [$];
   int unsigned  pixels_pending = 0;
   int unsigned  error_count    = 0;
   int unsigned  cycle_count    = 0;
   bit           steady_flow    = 1'b0;
   int unsigned  send_gap       = 0;
   int unsigned  take_stall     = 0;

   function automatic int unsigned disparity_for(input logic [DEPTH_W-1:0] depth);
      int unsigned den;
      int unsigned quot;
      den = int'(offset_setting) + int'(depth);
      if (den == 0)
         return 0;
      quot = (int'(gain_setting) * int'(depth)) / den;
      return (quot > MAX_SHIFT) ? MAX_SHIFT : quot;
   endfunction

   task automatic shift_pixel(input req_word_type w);
      int unsigned  pos;
      int unsigned  shift;
      int unsigned  col;
      rsp_word_type r;
      pos = (held_pixels > MAX_SHIFT) ? MAX_SHIFT : held_pixels;
      window_px[pos] = {w.red_in, w.green_in, w.blue_in};
      shift = disparity_for(w.depth);
      if (shift <= pos) begin
         col = pos - shift;
         // Column zero of a row never takes a shifted red.
         if (!(first_col_held && col == 0))
            window_px[col].red = w.red_in;
      end
      held_pixels = pos + 1;
      if (w.row_end) begin
         for (int unsigned i = 0; i < held_pixels; i++) begin
            r = {window_px[i].red, window_px[i].green, window_px[i].blue,
                 (i + 1 == held_pixels)};
            shifted_expected.push_back(r);
         end
         held_pixels    = 0;
         first_col_held = 1'b1;
      end else if (held_pixels == MAX_SHIFT + 1) begin
         r = {window_px[0].red, window_px[0].green, window_px[0].blue, 1'b0};
         shifted_expected.push_back(r);
         for (int unsigned i = 0; i < MAX_SHIFT; i++)
            window_px[i] = window_px[i + 1];
         held_pixels    = MAX_SHIFT;
         first_col_held = 1'b0;
      end
   endtask

   // Source side: present queued words, with bursts of idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            shift_pixel(req_chan.data);
            pixels_pending--;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (!steady_flow && $urandom_range(0, 6) == 0) begin
               send_gap = $urandom_range(0, 9);
               req_chan.valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
               req_chan.valid <= 1'b1;
               req_chan.data  <= pixel_queue.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result side: check each accepted word against the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (shifted_expected.size() == 0) begin
               error_count++;
               $display("%0t: unexpected word r=%0d g=%0d b=%0d done=%0b", $time,
                        rsp_chan.data.red_out, rsp_chan.data.green_out,
                        rsp_chan.data.blue_out, rsp_chan.data.row_done);
            end else begin
               want = shifted_expected.pop_front();
               if (rsp_chan.data !== want) begin
                  error_count++;
                  $display("%0t: expected r=%0d g=%0d b=%0d done=%0b, actual r=%0d g=%0d b=%0d done=%0b",
                           $time, want.red_out, want.green_out, want.blue_out, want.row_done,
                           rsp_chan.data.red_out, rsp_chan.data.green_out,
                           rsp_chan.data.blue_out, rsp_chan.data.row_done);
               end
            end
         end
         if (take_stall > 0) begin
            take_stall--;
            rsp_chan.ready <= 1'b0;
         end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
            take_stall = $urandom_range(0, 9);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic queue_pixel(input int unsigned red, input int unsigned green,
                              input int unsigned blue, input int unsigned depth,
                              input bit last);
      req_word_type w;
      w.red_in   = red[COLOR_W-1:0];
      w.green_in = green[COLOR_W-1:0];
      w.blue_in  = blue[COLOR_W-1:0];
      w.depth    = depth[DEPTH_W-1:0];
      w.row_end  = last;
      pixel_queue.push_back(w);
      pixels_pending++;
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_GAIN)
         gain_setting = value[GAIN_W-1:0];
      else
         offset_setting = value[OFFSET_W-1:0];
   endtask

   // Every phase ends on a row end, so an empty scoreboard means the core is idle
   // apart from the trailing cycles of its last word.
   task automatic wait_for_idle();
      do
         @(posedge clock);
      while (pixels_pending != 0 || shifted_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(input int unsigned gain, input int unsigned offset,
                                   input int unsigned count);
      int unsigned queued;
      int unsigned row_len;
      write_register(CSR_GAIN, gain);
      write_register(CSR_OFFSET, offset);
      queued = 0;
      while (queued < count) begin
         row_len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 30)
                                                : $urandom_range(1, 12);
         for (int unsigned i = 0; i < row_len; i++)
            queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255),
                        ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 255),
                        i == row_len - 1);
         queued += row_len;
      end
      wait_for_idle();
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_GAIN;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings. Column 0 and column 3 aim before the row, column 7 aims
      // at column zero, column 8 aims at column 1 after the window has slid.
      queue_pixel(255,   0, 255, 255, 1'b0);
      queue_pixel(  0, 255,   0,   0, 1'b0);
      queue_pixel( 17,  34,  51,  20, 1'b0);
      queue_pixel(200, 100,  50, 128, 1'b0);
      queue_pixel( 85, 170,  85,  60, 1'b0);
      queue_pixel(170,  85, 170,  40, 1'b0);
      queue_pixel(  1, 254, 128,  10, 1'b0);
      queue_pixel( 99,  11, 222, 255, 1'b0);
      queue_pixel(254,   1, 127, 255, 1'b0);
      queue_pixel(  3, 252,  60,  40, 1'b1);
      // A one-pixel row, then a row that just fills the window.
      queue_pixel(128, 127, 129, 255, 1'b1);
      for (int unsigned i = 0; i < MAX_SHIFT + 1; i++)
         queue_pixel(i * 31, 255 - i * 29, i * 17, i * 36, i == MAX_SHIFT);
      wait_for_idle();

      // Zero divisor: offset 0 with depth 0 gives no shift; large quotients saturate.
      write_register(CSR_OFFSET, 0);
      write_register(CSR_GAIN, 255);
      queue_pixel( 10,  20,  30,   0, 1'b0);
      queue_pixel( 40,  50,  60,   0, 1'b0);
      queue_pixel( 70,  80,  90, 255, 1'b0);
      queue_pixel(100, 110, 120,   0, 1'b1);
      wait_for_idle();

      run_random_phase(255, 1, 36);
      run_random_phase(0, 1023, 36);
      run_random_phase(255, 1023, 36);
      run_random_phase(200, 0, 30);
      repeat (3) run_random_phase($urandom_range(0, 255), $urandom_range(1, 400), 36);
      steady_flow = 1'b1;
      run_random_phase(GAIN_RESET, OFFSET_RESET, 36);

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/dsis_pkg.sv
rtl/dsis_req_if.sv
rtl/dsis_rsp_if.sv
rtl/dsis_div.sv
rtl/dsis_cell.sv
rtl/depth_image_stereo_shift_core.sv
dv/tb_depth_image_stereo_shift_core.sv
